// ===== rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg - shared types and constants of the PL/0 token scanner
// Token codes, error kinds, scan modes, keyword table and the record types
// that travel from the scanning front end through the queue to the back end.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Lexeme limits
    localparam int unsigned STORE_DEPTH = 11;
    localparam int unsigned IDENT_LEN   = 11;
    localparam int unsigned NUM_LEN     = 5;
    localparam int unsigned LEX_W       = 8 * STORE_DEPTH;
    localparam int unsigned HEAD_W      = 64;
    localparam int unsigned TAIL_W      = LEX_W - HEAD_W;

    // Effective run limits, clipped to the store depth
    localparam logic [3:0] IDENT_LIM =
        4'((IDENT_LEN > STORE_DEPTH) ? STORE_DEPTH : IDENT_LEN);
    localparam logic [3:0] NUM_LIM =
        4'((NUM_LEN > STORE_DEPTH) ? STORE_DEPTH : NUM_LEN);

    // Token queue, depth a power of two
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token codes
    localparam logic [5:0] TK_IDENT   = 6'd2;
    localparam logic [5:0] TK_NUMBER  = 6'd3;
    localparam logic [5:0] TK_PLUS    = 6'd4;
    localparam logic [5:0] TK_MINUS   = 6'd5;
    localparam logic [5:0] TK_TIMES   = 6'd6;
    localparam logic [5:0] TK_SLASH   = 6'd7;
    localparam logic [5:0] TK_FI      = 6'd8;
    localparam logic [5:0] TK_EQL     = 6'd9;
    localparam logic [5:0] TK_NEQ     = 6'd10;
    localparam logic [5:0] TK_LSS     = 6'd11;
    localparam logic [5:0] TK_LEQ     = 6'd12;
    localparam logic [5:0] TK_GTR     = 6'd13;
    localparam logic [5:0] TK_GEQ     = 6'd14;
    localparam logic [5:0] TK_LPAREN  = 6'd15;
    localparam logic [5:0] TK_RPAREN  = 6'd16;
    localparam logic [5:0] TK_COMMA   = 6'd17;
    localparam logic [5:0] TK_SEMI    = 6'd18;
    localparam logic [5:0] TK_PERIOD  = 6'd19;
    localparam logic [5:0] TK_BECOMES = 6'd20;
    localparam logic [5:0] TK_BEGIN   = 6'd21;
    localparam logic [5:0] TK_END     = 6'd22;
    localparam logic [5:0] TK_IF      = 6'd23;
    localparam logic [5:0] TK_THEN    = 6'd24;
    localparam logic [5:0] TK_WHILE   = 6'd25;
    localparam logic [5:0] TK_DO      = 6'd26;
    localparam logic [5:0] TK_CALL    = 6'd27;
    localparam logic [5:0] TK_CONST   = 6'd28;
    localparam logic [5:0] TK_VAR     = 6'd29;
    localparam logic [5:0] TK_PROC    = 6'd30;
    localparam logic [5:0] TK_WRITE   = 6'd31;
    localparam logic [5:0] TK_READ    = 6'd32;
    localparam logic [5:0] TK_ELSE    = 6'd33;
    localparam logic [5:0] TK_ERROR   = 6'd34;

    // Error kinds
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_NAME_LONG    = 3'd1;
    localparam logic [2:0] ERR_NUM_LONG     = 3'd2;
    localparam logic [2:0] ERR_INVALID      = 3'd3;
    localparam logic [2:0] ERR_OPEN_COMMENT = 3'd4;

    // Source characters of interest
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_PERIOD = ".";

    // Scan modes
    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_IDENT_LONG,
        M_NUM,
        M_NUM_LONG,
        M_LT,
        M_GT,
        M_COLON,
        M_SLASH,
        M_COMMENT,
        M_COMMENT_STAR
    } t_mode;

    typedef logic [STORE_DEPTH-1:0][7:0] t_store;
    typedef logic [LEX_W-1:0]            t_lex;

    // One token as delivered
    typedef struct packed {
        logic [5:0] code;
        logic [2:0] err;
        logic [3:0] len;
        t_lex       lex;
    } t_token;

    // Tokens caused by one source byte (one or two)
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Keyword spelling packed first character lowest
    function automatic t_lex to_lex(input logic [71:0] s, input int unsigned n);
        t_lex r;
        r = '0;
        for (int unsigned k = 0; k < 9; k++) begin
            if (k < n) begin
                r[8*k +: 8] = s[8*(n-1-k) +: 8];
            end
        end
        return r;
    endfunction

    localparam int unsigned KW_NUM = 14;

    localparam t_lex KW_LEX [KW_NUM] = '{
        to_lex("const", 5), to_lex("var", 3), to_lex("procedure", 9),
        to_lex("call", 4), to_lex("begin", 5), to_lex("end", 3),
        to_lex("if", 2), to_lex("fi", 2), to_lex("then", 4),
        to_lex("else", 4), to_lex("while", 5), to_lex("do", 2),
        to_lex("read", 4), to_lex("write", 5)
    };

    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2,
        4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5
    };

    localparam logic [5:0] KW_CODE [KW_NUM] = '{
        TK_CONST, TK_VAR, TK_PROC, TK_CALL, TK_BEGIN, TK_END, TK_IF,
        TK_FI, TK_THEN, TK_ELSE, TK_WHILE, TK_DO, TK_READ, TK_WRITE
    };

endpackage

// ===== rtl/pl0_token_scanner_core.sv =====
// ----------------------------------------------------------------------------
// pl0_token_scanner_core - PL/0 token scanner
// Turns a stream of source bytes into PL/0 tokens, one token per transfer.
// ----------------------------------------------------------------------------
// The scanner accepts one source byte per clock and hands out one token per
// clock when tokens wait and i_stall is low. A byte causes zero, one or two
// tokens; o_last_of_run marks the last token of each byte. The first token
// of a byte passes into the queue and then into the output register.
// Tokens wait in a four-entry queue between the scanning front end and the
// output register, so input is refused (o_stall high) only when that queue
// is full, which happens when the output side stalls or when bytes that
// cause two tokens arrive back to back, since the output register delivers
// one token per cycle. Raise i_final_char on the last byte of a text to
// flush any pending token; the scanner is then idle and ready for the next
// text.
module pl0_token_scanner_core
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_ch,
    input  logic              i_final_char,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [5:0]        o_token_code,
    output logic [2:0]        o_error_kind,
    output logic [3:0]        o_lexeme_len,
    output logic [HEAD_W-1:0] o_lexeme_head,
    output logic [TAIL_W-1:0] o_lexeme_tail,
    output logic              o_last_of_run
);

    t_push     w_push;
    t_rec      w_head;
    t_q_status w_qstat;
    logic      w_pop;

    // Scanning front end
    pts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_final_char (i_final_char),
        .i_qstat      (w_qstat),
        .o_push       (w_push)
    );

    // Token queue
    pts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    // Output back end
    pts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_token_code  (o_token_code),
        .o_error_kind  (o_error_kind),
        .o_lexeme_len  (o_lexeme_len),
        .o_lexeme_head (o_lexeme_head),
        .o_lexeme_tail (o_lexeme_tail),
        .o_last_of_run (o_last_of_run)
    );

    // Queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_qstat.full)
        else $error("token queue written while full");

    // Error code and error kind agree
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_token_code == TK_ERROR) == (o_error_kind != ERR_NONE)))
        else $error("error kind does not match token code");

    // Every token carries a lexeme within the store depth
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lexeme_len != 4'd0 && o_lexeme_len <= 4'(STORE_DEPTH)))
        else $error("lexeme length out of range");

    // Second token of a byte follows its first without a gap
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=> o_valid)
        else $error("second token of a byte missing");

endmodule

// ===== rtl/pts_front.sv =====
// ----------------------------------------------------------------------------
// pts_front - scanning front end
// Takes one source byte per transfer, tracks the scan mode and the lexeme
// store, and builds the one or two tokens that the byte completes.
// ----------------------------------------------------------------------------
module pts_front
    import pts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  logic [7:0] i_ch,
    input  logic      i_final_char,
    input  t_q_status i_qstat,
    output t_push     o_push
);

    typedef struct packed {
        logic   valid;
        t_token tok;
    } t_cand;

    // Character classes
    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {[8'h09:8'h0D], 8'h20});
    endfunction

    // Store contents below len, zero above
    function automatic t_lex mask_lex(input t_store s, input logic [3:0] n);
        t_lex r;
        r = '0;
        for (int unsigned k = 0; k < STORE_DEPTH; k++) begin
            if (4'(k) < n) begin
                r[8*k +: 8] = s[k];
            end
        end
        return r;
    endfunction

    function automatic t_lex lex1(input logic [7:0] a);
        t_lex r;
        r = '0;
        r[7:0] = a;
        return r;
    endfunction

    function automatic t_lex lex2(input logic [7:0] a, input logic [7:0] b);
        t_lex r;
        r = '0;
        r[15:0] = {b, a};
        return r;
    endfunction

    // Reserved word lookup, all keywords compared in parallel
    function automatic logic [5:0] kw_lookup(input t_lex lex, input logic [3:0] n);
        logic [5:0] code;
        code = TK_IDENT;
        for (int unsigned i = 0; i < KW_NUM; i++) begin
            if (n == KW_LEN[i] && lex == KW_LEX[i]) begin
                code = KW_CODE[i];
            end
        end
        return code;
    endfunction

    function automatic t_cand mk_tok(input logic [5:0] code, input logic [2:0] err,
                                     input logic [3:0] n, input t_lex lex);
        t_cand r;
        r.valid    = 1'b1;
        r.tok.code = code;
        r.tok.err  = err;
        r.tok.len  = n;
        r.tok.lex  = lex;
        return r;
    endfunction

    // Token still pending in a mode, as when a blank follows
    function automatic t_cand flush_tok(input t_mode m, input t_lex lex,
                                        input logic [3:0] n);
        t_cand r;
        r = '0;
        case (m)
            M_IDENT:        r = mk_tok(kw_lookup(lex, n), ERR_NONE, n, lex);
            M_IDENT_LONG:   r = mk_tok(TK_ERROR, ERR_NAME_LONG, n, lex);
            M_NUM:          r = mk_tok(TK_NUMBER, ERR_NONE, n, lex);
            M_NUM_LONG:     r = mk_tok(TK_ERROR, ERR_NUM_LONG, n, lex);
            M_LT:           r = mk_tok(TK_LSS, ERR_NONE, 4'd1, lex1(CH_LT));
            M_GT:           r = mk_tok(TK_GTR, ERR_NONE, 4'd1, lex1(CH_GT));
            M_COLON:        r = mk_tok(TK_ERROR, ERR_INVALID, 4'd1, lex1(CH_COLON));
            M_SLASH:        r = mk_tok(TK_SLASH, ERR_NONE, 4'd1, lex1(CH_SLASH));
            M_COMMENT,
            M_COMMENT_STAR: r = mk_tok(TK_ERROR, ERR_OPEN_COMMENT, 4'd2,
                                       lex2(CH_SLASH, CH_STAR));
            default:        r = '0;
        endcase
        return r;
    endfunction

    t_mode      r_mode, n_mode;
    logic [3:0] r_count, n_count;
    t_store     r_store;

    logic       w_acc;
    logic       w_alpha, w_digit, w_alnum, w_space;
    logic       w_used;
    t_mode      w_mode_mid;
    logic [3:0] w_cnt_mid;
    logic       w_wr_en;
    logic [3:0] w_wr_idx;
    t_store     w_store_mid;
    t_lex       w_lex_cur, w_lex_mid;
    t_cand      w_step_tok, w_start_tok, w_fin_tok;
    logic [5:0] w_sym_code;

    assign o_stall = i_qstat.full;
    assign w_acc   = i_valid && !i_qstat.full;

    assign w_alpha = is_alpha(i_ch);
    assign w_digit = is_digit(i_ch);
    assign w_alnum = w_alpha || w_digit;
    assign w_space = is_space(i_ch);

    // Next state: continue the current lexeme or restart from idle
    always_comb begin
        w_used     = 1'b1;
        w_mode_mid = r_mode;
        w_cnt_mid  = r_count;
        w_wr_en    = 1'b0;
        w_wr_idx   = r_count;
        case (r_mode)
            M_IDENT: begin
                if (w_alnum) begin
                    if (r_count < IDENT_LIM) begin
                        w_wr_en   = 1'b1;
                        w_cnt_mid = r_count + 4'd1;
                    end else begin
                        w_mode_mid = M_IDENT_LONG;
                    end
                end else begin
                    w_used = 1'b0;
                end
            end
            M_NUM: begin
                if (w_digit) begin
                    if (r_count < NUM_LIM) begin
                        w_wr_en   = 1'b1;
                        w_cnt_mid = r_count + 4'd1;
                    end else begin
                        w_mode_mid = M_NUM_LONG;
                    end
                end else begin
                    w_used = 1'b0;
                end
            end
            M_IDENT_LONG: w_used = w_alnum;
            M_NUM_LONG:   w_used = w_digit;
            M_LT: begin
                if (i_ch == CH_GT || i_ch == CH_EQ) begin
                    w_mode_mid = M_IDLE;
                end else begin
                    w_used = 1'b0;
                end
            end
            M_GT, M_COLON: begin
                if (i_ch == CH_EQ) begin
                    w_mode_mid = M_IDLE;
                end else begin
                    w_used = 1'b0;
                end
            end
            M_SLASH: begin
                if (i_ch == CH_STAR) begin
                    w_mode_mid = M_COMMENT;
                end else begin
                    w_used = 1'b0;
                end
            end
            M_COMMENT: begin
                if (i_ch == CH_STAR) begin
                    w_mode_mid = M_COMMENT_STAR;
                end
            end
            M_COMMENT_STAR: begin
                if (i_ch == CH_SLASH) begin
                    w_mode_mid = M_IDLE;
                end else if (i_ch != CH_STAR) begin
                    w_mode_mid = M_COMMENT;
                end
            end
            default: w_used = 1'b0;
        endcase

        // Byte not taken by the current lexeme starts a new one
        if (!w_used) begin
            w_mode_mid = M_IDLE;
            w_cnt_mid  = 4'd0;
            if (w_alnum) begin
                w_mode_mid = w_alpha ? M_IDENT : M_NUM;
                w_cnt_mid  = 4'd1;
                w_wr_en    = 1'b1;
                w_wr_idx   = 4'd0;
            end else begin
                case (i_ch)
                    CH_LT:    w_mode_mid = M_LT;
                    CH_GT:    w_mode_mid = M_GT;
                    CH_COLON: w_mode_mid = M_COLON;
                    CH_SLASH: w_mode_mid = M_SLASH;
                    default:  w_mode_mid = M_IDLE;
                endcase
            end
        end

        // End of text flushes and returns to idle
        n_mode  = i_final_char ? M_IDLE : w_mode_mid;
        n_count = i_final_char ? 4'd0 : w_cnt_mid;
    end

    // Store as seen after this byte's write
    always_comb begin
        w_store_mid = r_store;
        if (w_wr_en) begin
            w_store_mid[w_wr_idx] = i_ch;
        end
    end

    assign w_lex_cur = mask_lex(r_store, r_count);
    assign w_lex_mid = mask_lex(w_store_mid, w_cnt_mid);

    // Single-character symbols
    always_comb begin
        case (i_ch)
            CH_PLUS:   w_sym_code = TK_PLUS;
            CH_MINUS:  w_sym_code = TK_MINUS;
            CH_STAR:   w_sym_code = TK_TIMES;
            CH_EQ:     w_sym_code = TK_EQL;
            CH_LPAREN: w_sym_code = TK_LPAREN;
            CH_RPAREN: w_sym_code = TK_RPAREN;
            CH_COMMA:  w_sym_code = TK_COMMA;
            CH_SEMI:   w_sym_code = TK_SEMI;
            CH_PERIOD: w_sym_code = TK_PERIOD;
            default:   w_sym_code = TK_ERROR;
        endcase
    end

    // Outputs: token ended by this byte, token of the byte itself, end flush
    always_comb begin
        w_step_tok = '0;
        if (!w_used) begin
            w_step_tok = flush_tok(r_mode, w_lex_cur, r_count);
        end else begin
            case (r_mode)
                M_LT: begin
                    if (i_ch == CH_GT) begin
                        w_step_tok = mk_tok(TK_NEQ, ERR_NONE, 4'd2, lex2(CH_LT, CH_GT));
                    end else begin
                        w_step_tok = mk_tok(TK_LEQ, ERR_NONE, 4'd2, lex2(CH_LT, CH_EQ));
                    end
                end
                M_GT:    w_step_tok = mk_tok(TK_GEQ, ERR_NONE, 4'd2, lex2(CH_GT, CH_EQ));
                M_COLON: w_step_tok = mk_tok(TK_BECOMES, ERR_NONE, 4'd2,
                                             lex2(CH_COLON, CH_EQ));
                default: w_step_tok = '0;
            endcase
        end

        w_start_tok = '0;
        if (!w_used && !w_space && !w_alnum && i_ch != CH_LT && i_ch != CH_GT
                && i_ch != CH_COLON && i_ch != CH_SLASH) begin
            w_start_tok = mk_tok(w_sym_code,
                                 (w_sym_code == TK_ERROR) ? ERR_INVALID : ERR_NONE,
                                 4'd1, lex1(i_ch));
        end

        w_fin_tok = '0;
        if (i_final_char) begin
            w_fin_tok = flush_tok(w_mode_mid, w_lex_mid, w_cnt_mid);
        end

        // Pack the first two tokens in order
        o_push = '0;
        if (w_step_tok.valid) begin
            o_push.rec.tok0 = w_step_tok.tok;
            o_push.rec.two  = w_start_tok.valid || w_fin_tok.valid;
            o_push.rec.tok1 = w_start_tok.valid ? w_start_tok.tok : w_fin_tok.tok;
        end else if (w_start_tok.valid) begin
            o_push.rec.tok0 = w_start_tok.tok;
            o_push.rec.two  = w_fin_tok.valid;
            o_push.rec.tok1 = w_fin_tok.tok;
        end else begin
            o_push.rec.tok0 = w_fin_tok.tok;
        end
        o_push.valid = w_acc && (w_step_tok.valid || w_start_tok.valid || w_fin_tok.valid);
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_count <= 4'd0;
        end else if (w_acc) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    // Lexeme store, payload only
    always_ff @(posedge i_clk) begin
        if (w_acc && w_wr_en) begin
            r_store[w_wr_idx] <= i_ch;
        end
    end

endmodule

// ===== rtl/pts_queue.sv =====
// ----------------------------------------------------------------------------
// pts_queue - token record queue
// Short circular queue between the front end and the back end; at most one
// record written and one read per cycle.
// ----------------------------------------------------------------------------
module pts_queue
    import pts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_rec      o_head,
    output t_q_status o_qstat
);

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push.valid && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push.valid && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    // Record storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.rec;
        end
    end

endmodule

// ===== rtl/pts_back.sv =====
// ----------------------------------------------------------------------------
// pts_back - token delivery back end
// Splits each queued record into its tokens and drives them one per
// transfer from an output register, marking the last token of a byte.
// ----------------------------------------------------------------------------
module pts_back
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rec              i_head,
    input  t_q_status         i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [5:0]        o_token_code,
    output logic [2:0]        o_error_kind,
    output logic [3:0]        o_lexeme_len,
    output logic [HEAD_W-1:0] o_lexeme_head,
    output logic [TAIL_W-1:0] o_lexeme_tail,
    output logic              o_last_of_run
);

    logic   r_valid;
    logic   r_slot;
    t_token r_tok;
    logic   r_last;

    logic   w_load;
    logic   w_last;
    t_token w_sel;

    // Load a token when the output register is free or being taken
    assign w_load = !i_qstat.empty && (!r_valid || !i_stall);
    assign w_sel  = r_slot ? i_head.tok1 : i_head.tok0;
    assign w_last = r_slot || !i_head.two;
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 1'b0;
        end else begin
            if (!r_valid || !i_stall) begin
                r_valid <= !i_qstat.empty;
            end
            if (w_load) begin
                r_slot <= !w_last;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tok  <= w_sel;
            r_last <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_token_code  = r_tok.code;
    assign o_error_kind  = r_tok.err;
    assign o_lexeme_len  = r_tok.len;
    assign o_lexeme_head = r_tok.lex[HEAD_W-1:0];
    assign o_lexeme_tail = r_tok.lex[LEX_W-1:HEAD_W];
    assign o_last_of_run = r_last;

endmodule
